// File: rtl/core/rbq_pkg.sv
// Shared types, widths and constants of the resonant biquad filter.
// No dependencies; every other file in rtl/core imports this package.
`default_nettype none

package rbq_pkg;

    localparam int SAMPLE_W  = 24;                // Q1.23 audio sample
    localparam int STATE_W   = 32;                // Q9.23 delay values
    localparam int COEF_W    = 18;                // Q2.16 coefficients
    localparam int FRAC_C    = 16;                // coefficient fraction bits
    localparam int MUL_OP_W  = STATE_W + 2;       // w1, w2 and (w0 - b*w1)
    localparam int PROD_W    = COEF_W + MUL_OP_W;
    localparam int ACC_W     = PROD_W - FRAC_C;   // rounded product / sums

    localparam logic signed [COEF_W-1:0] PC_RESET = -18'sd120284;
    localparam logic signed [COEF_W-1:0] C_W2     = 18'sd55723;  // 0.8502684
    localparam logic signed [COEF_W-1:0] C_ZERO   = 18'sd69403;  // 1.059
    localparam logic signed [COEF_W-1:0] C_GAIN   = 18'sd20724;  // 0.31622776

    localparam logic signed [ACC_W-1:0] W_MAX =
        ACC_W'((longint'(1) <<< (STATE_W - 1)) - longint'(1));
    localparam logic signed [ACC_W-1:0] W_MIN = -W_MAX - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] Y_MAX =
        ACC_W'((longint'(1) <<< (SAMPLE_W - 1)) - longint'(1));
    localparam logic signed [ACC_W-1:0] Y_MIN = -Y_MAX - ACC_W'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_A1,
        ST_MUL_W2,
        ST_MUL_Z,
        ST_DIFF,
        ST_MUL_G,
        ST_OUT
    } rbq_state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_MUL_A1,    // p = a1 * w1
        OP_MUL_W2,    // acc = x - rnd(p); p = c2 * w2
        OP_MUL_Z,     // w0 = sat(acc - rnd(p)); p = b * w1
        OP_DIFF,      // u = w0 - rnd(p); shift delay line
        OP_MUL_G,     // p = g * u
        OP_OUT        // y = sat(rnd(p)) into the output register
    } rbq_op_t;

    typedef struct packed {
        logic    in_ready;
        rbq_op_t op;
    } rbq_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic out_free;
    } rbq_status_t;

    // round half up to the coefficient's fraction bits
    function automatic logic signed [ACC_W-1:0] rnd_q16(
        input logic signed [PROD_W-1:0] p
    );
        logic signed [PROD_W-1:0] t;
        t = p + (PROD_W'(1) <<< (FRAC_C - 1));
        return t[PROD_W-1:FRAC_C];
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/rbq_stream_if.sv
// Valid/ready stream interfaces for input samples and filtered results.
// Depends on rbq_pkg for the sample width.
`default_nettype none

interface rbq_in_if;
    import rbq_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       block_end;

    modport source (output valid, output sample_in, output block_end, input ready);
    modport sink   (input valid, input sample_in, input block_end, output ready);
endinterface

interface rbq_out_if;
    import rbq_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       block_end_out;
    logic                       clipped;

    modport source (output valid, output sample_out, output block_end_out,
                    output clipped, input ready);
    modport sink   (input valid, input sample_out, input block_end_out,
                    input clipped, output ready);
endinterface

`default_nettype wire

// File: rtl/core/resonant_biquad_filter_top.sv
// Resonant biquad top level. After an input transfer the sequencer steps the
// sample through MUL_A1, MUL_W2, MUL_Z, DIFF, MUL_G and OUT, six steps around
// the single shared 18x34 multiplier; OUT waits until the output register is
// free, and the next sample is taken only back in idle. Reset (rst_n, async,
// active low) clears the delay line and output valid and loads a1 = -120284.
// Depends on rbq_pkg, rbq_stream_if, rbq_ctrl and rbq_datapath.
`default_nettype none

module resonant_biquad_filter_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic signed [rbq_pkg::COEF_W-1:0] cfg_wdata,
    rbq_in_if.sink                                 sample_stream,
    rbq_out_if.source                              result_stream
);
    import rbq_pkg::*;

    rbq_cmd_t    cmd;
    rbq_status_t status;

    rbq_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    rbq_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .cmd           (cmd),
        .status        (status),
        .sample_stream (sample_stream),
        .result_stream (result_stream)
    );

endmodule

`default_nettype wire

// File: rtl/core/rbq_ctrl.sv
// Sequencer of the biquad: steps one sample through the shared multiplier.
// Depends on rbq_pkg (state, command and status types).
`default_nettype none

module rbq_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire rbq_pkg::rbq_status_t status,
    output      rbq_pkg::rbq_cmd_t    cmd
);
    import rbq_pkg::*;

    rbq_state_t state_reg;
    rbq_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (status.in_valid) state_next = ST_MUL_A1;
            ST_MUL_A1: state_next = ST_MUL_W2;
            ST_MUL_W2: state_next = ST_MUL_Z;
            ST_MUL_Z:  state_next = ST_DIFF;
            ST_DIFF:   state_next = ST_MUL_G;
            ST_MUL_G:  state_next = ST_OUT;
            ST_OUT:    if (status.out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.in_ready = 1'b0;
        cmd.op       = OP_NONE;
        case (state_reg)
            ST_IDLE:   cmd.in_ready = 1'b1;
            ST_MUL_A1: cmd.op = OP_MUL_A1;
            ST_MUL_W2: cmd.op = OP_MUL_W2;
            ST_MUL_Z:  cmd.op = OP_MUL_Z;
            ST_DIFF:   cmd.op = OP_DIFF;
            ST_MUL_G:  cmd.op = OP_MUL_G;
            // hold the finished product until the output register frees up
            ST_OUT:    if (status.out_free) cmd.op = OP_OUT;
            default:   cmd.op = OP_NONE;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/rbq_datapath.sv
// Datapath of the biquad: coefficient register, delay line, one shared
// multiplier, accumulator and output register. Depends on rbq_pkg, rbq_stream_if.
`default_nettype none

module rbq_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic signed [rbq_pkg::COEF_W-1:0] cfg_wdata,
    input  wire rbq_pkg::rbq_cmd_t                 cmd,
    output      rbq_pkg::rbq_status_t              status,
    rbq_in_if.sink                                 sample_stream,
    rbq_out_if.source                              result_stream
);
    import rbq_pkg::*;

    logic signed [COEF_W-1:0]   pole_reg;
    logic signed [STATE_W-1:0]  w1_reg;
    logic signed [STATE_W-1:0]  w2_reg;
    logic signed [SAMPLE_W-1:0] x_reg;
    logic                       last_reg;
    logic signed [PROD_W-1:0]   p_reg;
    logic signed [PROD_W-1:0]   p_next;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [STATE_W-1:0]  w0_reg;
    logic signed [MUL_OP_W-1:0] u_reg;
    logic                       clip_reg;

    logic signed [SAMPLE_W-1:0] y_reg;
    logic                       y_last_reg;
    logic                       y_clip_reg;
    logic                       out_valid_reg;

    logic signed [COEF_W-1:0]   mul_a;
    logic signed [MUL_OP_W-1:0] mul_b;
    logic signed [ACC_W-1:0]    p_rnd;
    logic signed [ACC_W-1:0]    w0_raw;
    logic signed [ACC_W-1:0]    u_full;
    logic                       in_xfer;
    logic                       w0_hi;
    logic                       w0_lo;
    logic                       y_hi;
    logic                       y_lo;

    assign sample_stream.ready = cmd.in_ready;
    assign in_xfer = sample_stream.valid && cmd.in_ready;

    assign status.in_valid = sample_stream.valid;
    assign status.out_free = !out_valid_reg || result_stream.ready;

    assign result_stream.valid         = out_valid_reg;
    assign result_stream.sample_out    = y_reg;
    assign result_stream.block_end_out = y_last_reg;
    assign result_stream.clipped       = y_clip_reg;

    // operand selection for the shared multiplier
    always_comb
    begin
        mul_a = C_W2;
        mul_b = MUL_OP_W'(w2_reg);
        case (cmd.op)
            OP_MUL_A1:
            begin
                mul_a = pole_reg;
                mul_b = MUL_OP_W'(w1_reg);
            end
            OP_MUL_W2:
            begin
                mul_a = C_W2;
                mul_b = MUL_OP_W'(w2_reg);
            end
            OP_MUL_Z:
            begin
                mul_a = C_ZERO;
                mul_b = MUL_OP_W'(w1_reg);
            end
            OP_MUL_G:
            begin
                mul_a = C_GAIN;
                mul_b = u_reg;
            end
            default:
            begin
                mul_a = C_W2;
                mul_b = MUL_OP_W'(w2_reg);
            end
        endcase
    end

    assign p_next = mul_a * mul_b;
    assign p_rnd  = rnd_q16(p_reg);
    assign w0_raw = acc_reg - p_rnd;
    assign u_full = ACC_W'(w0_reg) - p_rnd;
    assign w0_hi  = w0_raw > W_MAX;
    assign w0_lo  = w0_raw < W_MIN;
    assign y_hi   = p_rnd > Y_MAX;
    assign y_lo   = p_rnd < Y_MIN;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pole_reg      <= PC_RESET;
            w1_reg        <= '0;
            w2_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                pole_reg <= cfg_wdata;
            end
            if (cmd.op == OP_DIFF)
            begin
                w2_reg <= w1_reg;
                w1_reg <= w0_reg;
            end
            if (cmd.op == OP_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_stream.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            x_reg    <= sample_stream.sample_in;
            last_reg <= sample_stream.block_end;
        end
        if (cmd.op inside {OP_MUL_A1, OP_MUL_W2, OP_MUL_Z, OP_MUL_G})
        begin
            p_reg <= p_next;
        end
        if (cmd.op == OP_MUL_W2)
        begin
            acc_reg <= ACC_W'(x_reg) - p_rnd;
        end
        if (cmd.op == OP_MUL_Z)
        begin
            if (w0_hi)
            begin
                w0_reg <= W_MAX[STATE_W-1:0];
            end
            else if (w0_lo)
            begin
                w0_reg <= W_MIN[STATE_W-1:0];
            end
            else
            begin
                w0_reg <= w0_raw[STATE_W-1:0];
            end
            clip_reg <= w0_hi || w0_lo;
        end
        if (cmd.op == OP_DIFF)
        begin
            u_reg <= u_full[MUL_OP_W-1:0];
        end
        if (cmd.op == OP_OUT)
        begin
            if (y_hi)
            begin
                y_reg <= Y_MAX[SAMPLE_W-1:0];
            end
            else if (y_lo)
            begin
                y_reg <= Y_MIN[SAMPLE_W-1:0];
            end
            else
            begin
                y_reg <= p_rnd[SAMPLE_W-1:0];
            end
            y_last_reg <= last_reg;
            y_clip_reg <= clip_reg || y_hi || y_lo;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/rbq_checker.sv
// Port-level checks of the resonant biquad top level, attached by bind.
// Depends on rbq_pkg for the sample width and on resonant_biquad_filter_top.
`default_nettype none

module rbq_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             in_valid,
    input wire logic                             in_ready,
    input wire logic                             out_valid,
    input wire logic                             out_ready,
    input wire logic [rbq_pkg::SAMPLE_W-1:0]     sample_out,
    input wire logic                             block_end_out,
    input wire logic                             clipped
);
    import rbq_pkg::*;

    logic in_xfer;

    assign in_xfer = in_valid && in_ready;

    // no result may be shown once reset has been seen at an edge
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("result valid during reset");

    // one sample in work at a time: in_ready stays low after a transfer while the sample is in work
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !in_ready ##1 !in_ready ##1 !in_ready
                    ##1 !in_ready ##1 !in_ready ##1 !in_ready)
        else $error("input taken while a sample is still in work");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample_out)
                                    && $stable(block_end_out) && $stable(clipped))
        else $error("stalled result changed or dropped");

endmodule

bind resonant_biquad_filter_top rbq_checker u_rbq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (sample_stream.valid),
    .in_ready      (sample_stream.ready),
    .out_valid     (result_stream.valid),
    .out_ready     (result_stream.ready),
    .sample_out    (result_stream.sample_out),
    .block_end_out (result_stream.block_end_out),
    .clipped       (result_stream.clipped)
);

`default_nettype wire
